### hdl/wsi_pkg.sv
package wsi_pkg;

	localparam int COUNT_BITS = 20;
	localparam int Z_BITS     = 32;
	localparam int Z2_BITS    = 2 * Z_BITS;
	localparam int OUT_BITS   = 32;
	localparam int OUT_FRAC   = 31;
	localparam int D_FRAC     = 90;
	localparam int P_FRAC     = 74;
	localparam int Z2_TO_D    = 32;
	localparam int Z2_TO_P    = 16;

	localparam logic [Z_BITS-1:0] Z_RESET = 32'd1052266988;

	// quotient of 4s(n-s)*2^90/n, then radicand and its root
	localparam int Q1_BITS = COUNT_BITS + D_FRAC;
	localparam int ROOT_W  = (COUNT_BITS + D_FRAC + 2) / 2;
	localparam int RAD_W   = 2 * ROOT_W;
	localparam int T_W     = Z_BITS + ROOT_W;
	localparam int C_W     = COUNT_BITS + P_FRAC + 2;
	localparam int R_W     = COUNT_BITS + P_FRAC + 3;

	typedef struct packed {
		logic [COUNT_BITS-1:0] successes;
		logic [COUNT_BITS-1:0] trials;
	} in_t;

	typedef struct packed {
		logic [OUT_BITS-1:0] lower_bound;
		logic [OUT_BITS-1:0] upper_bound;
		logic                input_error;
	} out_t;

	typedef struct packed {
		logic                  err;
		logic [Z_BITS-1:0]     z;
		logic [Z2_BITS-1:0]    z2;
		logic [COUNT_BITS-1:0] s;
		logic [COUNT_BITS-1:0] n;
	} front_tag_t;

	typedef struct packed {
		logic err;
		logic neg;
		logic sat;
	} lo_tag_t;

endpackage

### hdl/wsi_div.sv
module wsi_div #(
	parameter int DW    = 20,
	parameter int K     = 31,
	parameter int TAG_W = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic             start_valid,
	input  logic [DW-1:0]    rem_init,
	input  logic [K-1:0]     dividend_low,
	input  logic [DW-1:0]    divisor,
	input  logic [TAG_W-1:0] tag,
	output logic             done_valid,
	output logic [K-1:0]     quotient,
	output logic [TAG_W-1:0] done_tag
);

	logic             valid_s [0:K-1];
	logic [DW-1:0]    rem_s   [0:K-1];
	logic [K-1:0]     bits_s  [0:K-1];
	logic [K-1:0]     quo_s   [0:K-1];
	logic [DW-1:0]    den_s   [0:K-1];
	logic [TAG_W-1:0] tag_s   [0:K-1];

	for (genvar k = 0; k < K; k++) begin : g_step
		logic             prv_valid;
		logic [DW-1:0]    prv_rem;
		logic [K-1:0]     prv_bits;
		logic [K-1:0]     prv_quo;
		logic [DW-1:0]    prv_den;
		logic [TAG_W-1:0] prv_tag;
		logic [DW:0]      shifted;
		logic [DW:0]      diff;
		logic             ge;

		if (k == 0) begin : g_first
			assign prv_valid = start_valid;
			assign prv_rem   = rem_init;
			assign prv_bits  = dividend_low;
			assign prv_quo   = '0;
			assign prv_den   = divisor;
			assign prv_tag   = tag;
		end else begin : g_next
			assign prv_valid = valid_s[k-1];
			assign prv_rem   = rem_s[k-1];
			assign prv_bits  = bits_s[k-1];
			assign prv_quo   = quo_s[k-1];
			assign prv_den   = den_s[k-1];
			assign prv_tag   = tag_s[k-1];
		end

		assign shifted = {prv_rem, prv_bits[K-1]};
		assign diff    = shifted - {1'b0, prv_den};
		assign ge      = shifted >= {1'b0, prv_den};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (advance) begin
				valid_s[k] <= prv_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				rem_s[k]  <= ge ? diff[DW-1:0] : shifted[DW-1:0];
				bits_s[k] <= {prv_bits[K-2:0], 1'b0};
				quo_s[k]  <= {prv_quo[K-2:0], ge};
				den_s[k]  <= prv_den;
				tag_s[k]  <= prv_tag;
			end
		end
	end

	assign done_valid = valid_s[K-1];
	assign quotient   = quo_s[K-1];
	assign done_tag   = tag_s[K-1];

endmodule

### hdl/wsi_sqrt.sv
module wsi_sqrt #(
	parameter int HALF_W = 56,
	parameter int TAG_W  = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic                start_valid,
	input  logic [2*HALF_W-1:0] radicand,
	input  logic [TAG_W-1:0]    tag,
	output logic                done_valid,
	output logic [HALF_W-1:0]   root,
	output logic [TAG_W-1:0]    done_tag
);

	logic                valid_s [0:HALF_W-1];
	logic [2*HALF_W-1:0] rad_s   [0:HALF_W-1];
	logic [HALF_W+1:0]   rem_s   [0:HALF_W-1];
	logic [HALF_W-1:0]   root_s  [0:HALF_W-1];
	logic [TAG_W-1:0]    tag_s   [0:HALF_W-1];

	for (genvar k = 0; k < HALF_W; k++) begin : g_step
		logic                prv_valid;
		logic [2*HALF_W-1:0] prv_rad;
		logic [HALF_W+1:0]   prv_rem;
		logic [HALF_W-1:0]   prv_root;
		logic [TAG_W-1:0]    prv_tag;
		logic [HALF_W+3:0]   shifted;
		logic [HALF_W+3:0]   trial;
		logic [HALF_W+3:0]   diff;
		logic                ge;

		if (k == 0) begin : g_first
			assign prv_valid = start_valid;
			assign prv_rad   = radicand;
			assign prv_rem   = '0;
			assign prv_root  = '0;
			assign prv_tag   = tag;
		end else begin : g_next
			assign prv_valid = valid_s[k-1];
			assign prv_rad   = rad_s[k-1];
			assign prv_rem   = rem_s[k-1];
			assign prv_root  = root_s[k-1];
			assign prv_tag   = tag_s[k-1];
		end

		// bring down the next two radicand bits, try root*4+1
		assign shifted = {prv_rem, prv_rad[2*HALF_W-1:2*HALF_W-2]};
		assign trial   = {2'b00, prv_root, 2'b01};
		assign diff    = shifted - trial;
		assign ge      = shifted >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (advance) begin
				valid_s[k] <= prv_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				rad_s[k]  <= {prv_rad[2*HALF_W-3:0], 2'b00};
				rem_s[k]  <= ge ? diff[HALF_W+1:0] : shifted[HALF_W+1:0];
				root_s[k] <= {prv_root[HALF_W-2:0], ge};
				tag_s[k]  <= prv_tag;
			end
		end
	end

	assign done_valid = valid_s[HALF_W-1];
	assign root       = root_s[HALF_W-1];
	assign done_tag   = tag_s[HALF_W-1];

endmodule

### hdl/wilson_score_interval_top.sv
// Wilson score interval pipeline: each transaction of (successes, trials) yields
// one transaction of Q1.31 lower and upper bounds at the quantile held in the z
// register (Q3.29; the user must write it through the cfg channel while the block is
// idle, as the block itself does not enforce this). A new item can enter every cycle
// unless downstream back pressure stalls the pipeline. Each item passes through the
// bit-per-stage long division of 4s(n-s)*2^90/n (COUNT_BITS + 90 stages), the
// bit-per-stage square root of the radicand (ROOT_W stages), the 31-step output
// dividers, and the registered stages 1 to 7 and the output register around them.
// Invalid items (zero trials or successes above trials) give zero bounds with
// input_error set. Downstream back pressure stalls the whole pipeline at once.
module wilson_score_interval_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  wsi_pkg::in_t                    in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output wsi_pkg::out_t                   out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [wsi_pkg::Z_BITS-1:0]      cfg_data
);

	localparam int N    = wsi_pkg::COUNT_BITS;
	localparam int ZB   = wsi_pkg::Z_BITS;
	localparam int Z2B  = wsi_pkg::Z2_BITS;
	localparam int Q1B  = wsi_pkg::Q1_BITS;
	localparam int RTW  = wsi_pkg::ROOT_W;
	localparam int RADW = wsi_pkg::RAD_W;
	localparam int TW   = wsi_pkg::T_W;
	localparam int CW   = wsi_pkg::C_W;
	localparam int RW   = wsi_pkg::R_W;
	localparam int OF   = wsi_pkg::OUT_FRAC;
	localparam int OB   = wsi_pkg::OUT_BITS;

	logic              advance;
	logic [ZB-1:0]     z_q;

	// stage 1
	logic              valid_s1;
	logic              err_s1;
	logic [N-1:0]      s_s1, n_s1, diff_s1;
	logic [ZB-1:0]     z_s1;
	logic [Z2B-1:0]    z2_s1;
	// stage 2
	logic              valid_s2;
	logic [2*N-1:0]    sd_w;
	logic [2*N-1:0]    prod_s2;
	wsi_pkg::front_tag_t tag_s2;
	// first divider
	logic              q1_valid;
	logic [Q1B-1:0]    q1;
	wsi_pkg::front_tag_t q1_tag;
	// stage 3
	logic              valid_s3;
	logic [RADW-1:0]   rad_s3;
	wsi_pkg::front_tag_t tag_s3;
	// root
	logic              rt_valid;
	logic [RTW-1:0]    rt;
	wsi_pkg::front_tag_t rt_tag;
	// stage 4
	logic              valid_s4, err_s4;
	logic [2*ZB-1:0]   plo_s4;
	logic [RTW-1:0]    phi_s4;
	logic [CW-1:0]     c_s4;
	logic [RW-1:0]     den_s4;
	// stage 5
	logic              valid_s5, err_s5;
	logic [TW-1:0]     t_s5;
	logic [CW-1:0]     c_s5;
	logic [RW-1:0]     den_s5;
	// stage 6
	logic              valid_s6, err_s6, neg_s6;
	logic [RW-1:0]     numlo_s6, numhi_s6, den_s6;
	// stage 7
	logic              valid_s7;
	logic [RW-1:0]     remlo_s7, remhi_s7, den_s7;
	wsi_pkg::lo_tag_t  lotag_s7;
	logic              sathi_s7;
	// output dividers
	logic              lo_valid, hi_valid;
	logic [OF-1:0]     qlo, qhi;
	wsi_pkg::lo_tag_t  lo_tag;
	logic              hi_sat;
	// output register
	logic              out_valid_q;
	wsi_pkg::out_t     out_data_q;

	assign advance   = !out_valid_q || out_ready;
	assign in_ready  = advance;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			z_q <= wsi_pkg::Z_RESET;
		end else if (cfg_valid && cfg_ready) begin
			z_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			valid_s5    <= 1'b0;
			valid_s6    <= 1'b0;
			valid_s7    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= in_valid;
			valid_s2    <= valid_s1;
			valid_s3    <= q1_valid;
			valid_s4    <= rt_valid;
			valid_s5    <= valid_s4;
			valid_s6    <= valid_s5;
			valid_s7    <= valid_s6;
			out_valid_q <= lo_valid && hi_valid;
		end
	end

	assign sd_w = (2*N)'(s_s1) * (2*N)'(diff_s1);

	always_ff @(posedge clk) begin
		if (advance) begin
			// stage 1: validity, n - s, z squared
			s_s1    <= in_data.successes;
			n_s1    <= in_data.trials;
			diff_s1 <= in_data.trials - in_data.successes;
			err_s1  <= (in_data.trials == '0) || (in_data.successes > in_data.trials);
			z_s1    <= z_q;
			z2_s1   <= Z2B'(z_q) * Z2B'(z_q);

			// stage 2: 4s(n-s)
			prod_s2    <= {sd_w[2*N-3:0], 2'b00};
			tag_s2.err <= err_s1;
			tag_s2.z   <= z_s1;
			tag_s2.z2  <= z2_s1;
			tag_s2.s   <= s_s1;
			tag_s2.n   <= n_s1;

			// stage 3: radicand
			rad_s3 <= RADW'(q1) + (RADW'(q1_tag.z2) << wsi_pkg::Z2_TO_D);
			tag_s3 <= q1_tag;

			// stage 4: split z*r, form numerator base and denominator
			err_s4 <= rt_tag.err;
			plo_s4 <= (2*ZB)'(rt_tag.z) * (2*ZB)'(rt[31:0]);
			phi_s4 <= RTW'(rt_tag.z) * RTW'(rt[RTW-1:32]);
			c_s4   <= (CW'(rt_tag.s) << (wsi_pkg::P_FRAC + 1))
				+ (CW'(rt_tag.z2) << wsi_pkg::Z2_TO_P);
			den_s4 <= ((RW'(rt_tag.n) << wsi_pkg::P_FRAC)
				+ (RW'(rt_tag.z2) << wsi_pkg::Z2_TO_P)) << 1;

			// stage 5: t = z*r
			err_s5 <= err_s4;
			t_s5   <= TW'(plo_s4) + (TW'(phi_s4) << 32);
			c_s5   <= c_s4;
			den_s5 <= den_s4;

			// stage 6: c -/+ t
			err_s6   <= err_s5;
			neg_s6   <= RW'(t_s5) >= RW'(c_s5);
			numlo_s6 <= RW'(c_s5) - RW'(t_s5);
			numhi_s6 <= RW'(c_s5) + RW'(t_s5);
			den_s6   <= den_s5;

			// stage 7: saturate where the ratio reaches one
			lotag_s7.err <= err_s6;
			lotag_s7.neg <= neg_s6;
			lotag_s7.sat <= numlo_s6 >= den_s6;
			sathi_s7     <= numhi_s6 >= den_s6;
			remlo_s7     <= (numlo_s6 >= den_s6) ? '0 : numlo_s6;
			remhi_s7     <= (numhi_s6 >= den_s6) ? '0 : numhi_s6;
			den_s7       <= den_s6;

			// output register
			out_data_q.input_error <= lo_tag.err;
			if (lo_tag.err || lo_tag.neg) begin
				out_data_q.lower_bound <= '0;
			end else if (lo_tag.sat) begin
				out_data_q.lower_bound <= OB'(1) << OF;
			end else begin
				out_data_q.lower_bound <= OB'(qlo);
			end
			if (lo_tag.err) begin
				out_data_q.upper_bound <= '0;
			end else if (hi_sat) begin
				out_data_q.upper_bound <= OB'(1) << OF;
			end else begin
				out_data_q.upper_bound <= OB'(qhi);
			end
		end
	end

	// floor(4s(n-s) * 2^90 / n); the top half of the product is already below n
	wsi_div #(
		.DW    (N),
		.K     (Q1B),
		.TAG_W ($bits(wsi_pkg::front_tag_t))
	) u_div_rad (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.start_valid  (valid_s2),
		.rem_init     (prod_s2[2*N-1:N]),
		.dividend_low ({prod_s2[N-1:0], {wsi_pkg::D_FRAC{1'b0}}}),
		.divisor      (tag_s2.n),
		.tag          (tag_s2),
		.done_valid   (q1_valid),
		.quotient     (q1),
		.done_tag     (q1_tag)
	);

	wsi_sqrt #(
		.HALF_W (RTW),
		.TAG_W  ($bits(wsi_pkg::front_tag_t))
	) u_sqrt (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.start_valid (valid_s3),
		.radicand    (rad_s3),
		.tag         (tag_s3),
		.done_valid  (rt_valid),
		.root        (rt),
		.done_tag    (rt_tag)
	);

	wsi_div #(
		.DW    (RW),
		.K     (OF),
		.TAG_W ($bits(wsi_pkg::lo_tag_t))
	) u_div_lo (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.start_valid  (valid_s7),
		.rem_init     (remlo_s7),
		.dividend_low ('0),
		.divisor      (den_s7),
		.tag          (lotag_s7),
		.done_valid   (lo_valid),
		.quotient     (qlo),
		.done_tag     (lo_tag)
	);

	wsi_div #(
		.DW    (RW),
		.K     (OF),
		.TAG_W (1)
	) u_div_hi (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.start_valid  (valid_s7),
		.rem_init     (remhi_s7),
		.dividend_low ('0),
		.divisor      (den_s7),
		.tag          (sathi_s7),
		.done_valid   (hi_valid),
		.quotient     (qhi),
		.done_tag     (hi_sat)
	);

endmodule
